FILE: src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared sizes, operation and status codes, and bit-scan helpers for the
// slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

   // Pool geometry. The slot index field is 10 bits wide, so the pool holds
   // 1024 slots; the count width also holds the end-of-list marker.
   localparam int NUM_SLOTS = 1024;
   localparam int SLOT_W    = 10;
   localparam int CNT_W     = SLOT_W + 1;

   // Live bits are kept as words so that a search covers one word a cycle.
   localparam int WORD_W    = 64;
   localparam int WBIT_W    = $clog2(WORD_W);
   localparam int NUM_WORDS = NUM_SLOTS / WORD_W;
   localparam int WADDR_W   = SLOT_W - WBIT_W;

   localparam int VER_W     = 32;

   localparam logic [CNT_W-1:0] END_MARK = CNT_W'(NUM_SLOTS);

   // Operation codes.
   localparam logic [2:0] FUNC_ALLOC = 3'd0;
   localparam logic [2:0] FUNC_FREE  = 3'd1;
   localparam logic [2:0] FUNC_CLEAR = 3'd2;
   localparam logic [2:0] FUNC_FWD   = 3'd3;
   localparam logic [2:0] FUNC_BWD   = 3'd4;
   localparam logic [2:0] FUNC_TEST  = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   typedef struct packed {
      logic              found;
      logic [WBIT_W-1:0] pos;
   } pick_type;

   // Lowest set bit of a word.
   function automatic pick_type pick_lowest(input logic [WORD_W-1:0] w);
      pick_type p;
      p = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            p.found = 1'b1;
            p.pos   = WBIT_W'(i);
         end
      end
      return p;
   endfunction

   // Highest set bit of a word.
   function automatic pick_type pick_highest(input logic [WORD_W-1:0] w);
      pick_type p;
      p = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) begin
            p.found = 1'b1;
            p.pos   = WBIT_W'(i);
         end
      end
      return p;
   endfunction

   // Bits of word w whose slot lies below the high-water mark.
   function automatic logic [WORD_W-1:0] below_mark(input logic [WADDR_W-1:0] w,
                                                    input logic [CNT_W-1:0]   mark);
      logic [WADDR_W:0]  mark_word;
      logic [WORD_W-1:0] m;
      mark_word = mark[CNT_W-1:WBIT_W];
      if ({1'b0, w} < mark_word) begin
         m = '1;
      end else if ({1'b0, w} == mark_word) begin
         m = (WORD_W'(1) << mark[WBIT_W-1:0]) - WORD_W'(1);
      end else begin
         m = '0;
      end
      return m;
   endfunction

endpackage

FILE: src/slot_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_top
// Fixed-size slot pool with a last-in-first-out free list, high-water mark,
// live-slot searches and a version counter.
// ----------------------------------------------------------------------------
// Each accepted item goes from IDLE to EXEC, through SCAN for a search that
// needs more words, and to OUT, which hands the result to the output register.
// Only IDLE takes an item, so the next one waits until OUT is done. A search
// reads one 64-bit live word per cycle from a one-read, one-write memory.
// Reset clears the sequencer, the free-list head, the high-water mark and the
// version; the live-bit and link memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module slot_pool_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_func,
   input  logic [spa_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [spa_pkg::SLOT_W-1:0]  rsp_result_index,
   output logic [spa_pkg::VER_W-1:0]   rsp_version
);

   // The sequencer: IDLE takes an item and starts the word reads, EXEC sees
   // the read data and does the whole operation or the first search word,
   // SCAN walks one word per cycle, and OUT hands the result to the output
   // register once that register is free.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [2:0]                     func_ff, func_in;
   logic [spa_pkg::SLOT_W-1:0]     idx_ff, idx_in;
   logic [spa_pkg::CNT_W-1:0]      head_ff, head_in;
   logic [spa_pkg::CNT_W-1:0]      hw_ff, hw_in;
   logic [spa_pkg::VER_W-1:0]      count_ff, count_in;
   logic [spa_pkg::WADDR_W-1:0]    scan_w_ff, scan_w_in;
   logic [1:0]                     pend_status_ff, pend_status_in;
   logic [spa_pkg::SLOT_W-1:0]     pend_index_ff, pend_index_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [spa_pkg::SLOT_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [spa_pkg::VER_W-1:0]      rsp_version_ff, rsp_version_in;

   // Live bits, one word per 64 slots, and the free-list links. Neither has
   // a reset value: only entries below the high-water mark are ever used,
   // and each of those was written by an allocation since the last clear.
   logic [spa_pkg::WORD_W-1:0]     live_mem [spa_pkg::NUM_WORDS];
   logic [spa_pkg::CNT_W-1:0]      link_mem [spa_pkg::NUM_SLOTS];

   logic [spa_pkg::WORD_W-1:0]     live_rd_ff;
   logic [spa_pkg::CNT_W-1:0]      link_rd_ff;

   logic                           live_we;
   logic [spa_pkg::WADDR_W-1:0]    live_raddr;
   logic [spa_pkg::WADDR_W-1:0]    live_waddr;
   logic [spa_pkg::WORD_W-1:0]     live_wdata;
   logic                           link_we;
   logic [spa_pkg::SLOT_W-1:0]     link_waddr;
   logic [spa_pkg::CNT_W-1:0]      link_wdata;

   // Decoded view of the item in flight.
   logic                           in_range;
   logic                           idx_live;
   logic [spa_pkg::WORD_W-1:0]     idx_onehot;
   logic [spa_pkg::WADDR_W-1:0]    cur_w;
   logic [spa_pkg::WADDR_W:0]      cur_w_next;
   logic                           fwd_end;
   logic [spa_pkg::WORD_W-1:0]     fwd_cand;
   logic [spa_pkg::WORD_W-1:0]     bwd_cand;
   spa_pkg::pick_type              fwd_pick;
   spa_pkg::pick_type              bwd_pick;
   logic                           out_free;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_version      = rsp_version_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign in_range   = ({1'b0, idx_ff} < hw_ff);
   assign idx_live   = in_range && live_rd_ff[idx_ff[spa_pkg::WBIT_W-1:0]];
   assign idx_onehot = spa_pkg::WORD_W'(1) << idx_ff[spa_pkg::WBIT_W-1:0];

   // The word under inspection: the item's own word in EXEC, the walking
   // word pointer in SCAN.
   assign cur_w      = (state_ff == ST_EXEC) ? idx_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W]
                                             : scan_w_ff;
   assign cur_w_next = {1'b0, cur_w} + 1'b1;
   // A forward search ends once the next word starts at or above the mark.
   assign fwd_end    = ({cur_w_next, {spa_pkg::WBIT_W{1'b0}}} >= hw_ff);

   // Forward candidates: at or after the start slot (first word only) and
   // below the mark. Backward candidates: at or before the start slot; all
   // of those lie below the mark since the start does.
   always_comb begin
      fwd_cand = live_rd_ff & spa_pkg::below_mark(cur_w, hw_ff);
      bwd_cand = live_rd_ff;
      if (state_ff == ST_EXEC) begin
         fwd_cand = fwd_cand & ({spa_pkg::WORD_W{1'b1}} << idx_ff[spa_pkg::WBIT_W-1:0]);
         bwd_cand = bwd_cand & ({spa_pkg::WORD_W{1'b1}} >>
                    (spa_pkg::WBIT_W'(spa_pkg::WORD_W - 1) - idx_ff[spa_pkg::WBIT_W-1:0]));
      end
   end

   assign fwd_pick = spa_pkg::pick_lowest(fwd_cand);
   assign bwd_pick = spa_pkg::pick_highest(bwd_cand);

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      hw_in          = hw_ff;
      count_in       = count_ff;
      scan_w_in      = scan_w_ff;
      pend_status_in = pend_status_ff;
      pend_index_in  = pend_index_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_version_in = rsp_version_ff;

      live_raddr     = scan_w_ff;
      live_we        = 1'b0;
      live_waddr     = idx_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W];
      live_wdata     = live_rd_ff;
      link_we        = 1'b0;
      link_waddr     = idx_ff;
      link_wdata     = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Start the word read now so that the data is there in EXEC.
            if (req_func == spa_pkg::FUNC_ALLOC) begin
               live_raddr = (head_ff < spa_pkg::END_MARK)
                          ? head_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W]
                          : hw_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W];
            end else begin
               live_raddr = req_slot_index[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W];
            end
            if (req_valid) begin
               func_in  = req_func;
               idx_in   = req_slot_index;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            pend_status_in = spa_pkg::ST_OK;
            pend_index_in  = '0;
            state_in       = ST_OUT;
            unique case (func_ff)
               spa_pkg::FUNC_ALLOC: begin
                  if (head_ff < spa_pkg::END_MARK) begin
                     // Pop the free list.
                     pend_index_in = head_ff[spa_pkg::SLOT_W-1:0];
                     live_we       = 1'b1;
                     live_waddr    = head_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W];
                     live_wdata    = live_rd_ff |
                                     (spa_pkg::WORD_W'(1) << head_ff[spa_pkg::WBIT_W-1:0]);
                     head_in       = (link_rd_ff > spa_pkg::END_MARK) ? spa_pkg::END_MARK
                                                                      : link_rd_ff;
                     count_in      = count_ff + 1'b1;
                  end else if (hw_ff < spa_pkg::END_MARK) begin
                     // Hand out a never-used slot and raise the mark.
                     pend_index_in = hw_ff[spa_pkg::SLOT_W-1:0];
                     live_we       = 1'b1;
                     live_waddr    = hw_ff[spa_pkg::SLOT_W-1:spa_pkg::WBIT_W];
                     live_wdata    = live_rd_ff |
                                     (spa_pkg::WORD_W'(1) << hw_ff[spa_pkg::WBIT_W-1:0]);
                     link_we       = 1'b1;
                     link_waddr    = hw_ff[spa_pkg::SLOT_W-1:0];
                     link_wdata    = spa_pkg::END_MARK;
                     hw_in         = hw_ff + 1'b1;
                     count_in      = count_ff + 1'b1;
                  end else begin
                     pend_status_in = spa_pkg::ST_FULL;
                  end
               end

               spa_pkg::FUNC_FREE: begin
                  if (idx_live) begin
                     live_we    = 1'b1;
                     live_wdata = live_rd_ff & ~idx_onehot;
                     link_we    = 1'b1;
                     head_in    = {1'b0, idx_ff};
                     count_in   = count_ff + 1'b1;
                  end else begin
                     pend_status_in = spa_pkg::ST_BAD;
                  end
               end

               spa_pkg::FUNC_CLEAR: begin
                  hw_in    = '0;
                  head_in  = spa_pkg::END_MARK;
                  count_in = count_ff + 1'b1;
               end

               spa_pkg::FUNC_TEST: begin
                  if (idx_live) begin
                     pend_index_in = idx_ff;
                  end else begin
                     pend_status_in = spa_pkg::ST_BAD;
                  end
               end

               spa_pkg::FUNC_FWD: begin
                  if (!in_range) begin
                     pend_status_in = spa_pkg::ST_NONE;
                  end else if (fwd_pick.found) begin
                     pend_index_in = {cur_w, fwd_pick.pos};
                  end else if (fwd_end) begin
                     pend_status_in = spa_pkg::ST_NONE;
                  end else begin
                     scan_w_in  = cur_w_next[spa_pkg::WADDR_W-1:0];
                     live_raddr = cur_w_next[spa_pkg::WADDR_W-1:0];
                     state_in   = ST_SCAN;
                  end
               end

               spa_pkg::FUNC_BWD: begin
                  if (!in_range) begin
                     pend_status_in = spa_pkg::ST_NONE;
                  end else if (bwd_pick.found) begin
                     pend_index_in = {cur_w, bwd_pick.pos};
                  end else if (cur_w == '0) begin
                     pend_status_in = spa_pkg::ST_NONE;
                  end else begin
                     scan_w_in  = cur_w - 1'b1;
                     live_raddr = cur_w - 1'b1;
                     state_in   = ST_SCAN;
                  end
               end

               default: begin
                  pend_status_in = spa_pkg::ST_BAD;
               end
            endcase
         end

         ST_SCAN: begin
            // One word per cycle; the next read is issued while this word
            // is examined.
            pend_status_in = spa_pkg::ST_OK;
            pend_index_in  = '0;
            if (func_ff == spa_pkg::FUNC_FWD) begin
               if (fwd_pick.found) begin
                  pend_index_in = {cur_w, fwd_pick.pos};
                  state_in      = ST_OUT;
               end else if (fwd_end) begin
                  pend_status_in = spa_pkg::ST_NONE;
                  state_in       = ST_OUT;
               end else begin
                  scan_w_in  = cur_w_next[spa_pkg::WADDR_W-1:0];
                  live_raddr = cur_w_next[spa_pkg::WADDR_W-1:0];
               end
            end else begin
               if (bwd_pick.found) begin
                  pend_index_in = {cur_w, bwd_pick.pos};
                  state_in      = ST_OUT;
               end else if (cur_w == '0) begin
                  pend_status_in = spa_pkg::ST_NONE;
                  state_in       = ST_OUT;
               end else begin
                  scan_w_in  = cur_w - 1'b1;
                  live_raddr = cur_w - 1'b1;
               end
            end
         end

         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pend_status_ff;
               rsp_index_in   = pend_index_ff;
               rsp_version_in = count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= spa_pkg::END_MARK;
         hw_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         hw_ff        <= hw_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff        <= func_in;
      idx_ff         <= idx_in;
      scan_w_ff      <= scan_w_in;
      pend_status_ff <= pend_status_in;
      pend_index_ff  <= pend_index_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_version_ff <= rsp_version_in;
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      live_rd_ff <= live_mem[live_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[head_ff[spa_pkg::SLOT_W-1:0]];
   end

   // The mark never passes the pool size.
   assert property (@(posedge clock) disable iff (reset)
      hw_ff <= spa_pkg::END_MARK)
      else $error("high-water mark beyond pool size");

   // The free-list head is either empty or a slot below the mark.
   assert property (@(posedge clock) disable iff (reset)
      (head_ff == spa_pkg::END_MARK) || (head_ff < hw_ff))
      else $error("free-list head outside the used range");

   // The version moves only when an operation executes.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_EXEC))
      else $error("version changed outside execution");

   // A failed result carries a zero index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != spa_pkg::ST_OK)) |-> (rsp_result_index == '0))
      else $error("failed result with nonzero index");

endmodule

FILE: verif/pool_checker.sv
// ----------------------------------------------------------------------------
// pool_checker
// Watches both channels of the slot pool allocator. It keeps its own model of
// the pool state, forms the expected result of every accepted item, and
// compares each accepted result field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module pool_checker
   import spa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_status,
   input  logic [SLOT_W-1:0] rsp_result_index,
   input  logic [VER_W-1:0]  rsp_version,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] index;
      logic [VER_W-1:0]  version;
   } pool_result_t;

   // Model of the pool: live flags, free-list links, list head, high-water
   // mark and the version counter.
   logic              live_map  [NUM_SLOTS];
   logic [CNT_W-1:0]  next_free [NUM_SLOTS];
   logic [CNT_W-1:0]  free_top;
   logic [CNT_W-1:0]  mark;
   logic [VER_W-1:0]  changes;

   pool_result_t      awaited_results[$];
   int                failures = 0;
   int                reports  = 0;

   // Applies one operation to the model and returns the result it yields.
   function automatic pool_result_t apply_pool_op(input logic [2:0]        op,
                                                  input logic [SLOT_W-1:0] slot);
      pool_result_t      r;
      logic [SLOT_W-1:0] s;
      r.status = ST_OK;
      r.index  = '0;
      case (op)
         FUNC_ALLOC: begin
            if (free_top < END_MARK) begin
               s             = free_top[SLOT_W-1:0];
               free_top      = next_free[s];
               live_map[s]   = 1'b1;
               changes       = changes + 1'b1;
               r.index       = s;
            end else if (mark < END_MARK) begin
               s             = mark[SLOT_W-1:0];
               live_map[s]   = 1'b1;
               next_free[s]  = END_MARK;
               mark          = mark + 1'b1;
               changes       = changes + 1'b1;
               r.index       = s;
            end else begin
               r.status = ST_FULL;
            end
         end
         FUNC_FREE: begin
            if ({1'b0, slot} < mark && live_map[slot]) begin
               live_map[slot]  = 1'b0;
               next_free[slot] = free_top;
               free_top        = {1'b0, slot};
               changes         = changes + 1'b1;
            end else begin
               r.status = ST_BAD;
            end
         end
         FUNC_CLEAR: begin
            mark     = '0;
            free_top = END_MARK;
            changes  = changes + 1'b1;
         end
         FUNC_FWD: begin
            r.status = ST_NONE;
            for (int i = int'(slot); i < int'(mark); i++) begin
               if (live_map[i]) begin
                  r.status = ST_OK;
                  r.index  = SLOT_W'(i);
                  break;
               end
            end
         end
         FUNC_BWD: begin
            r.status = ST_NONE;
            if ({1'b0, slot} < mark) begin
               for (int i = int'(slot); i >= 0; i--) begin
                  if (live_map[i]) begin
                     r.status = ST_OK;
                     r.index  = SLOT_W'(i);
                     break;
                  end
               end
            end
         end
         FUNC_TEST: begin
            if ({1'b0, slot} < mark && live_map[slot]) begin
               r.index = slot;
            end else begin
               r.status = ST_BAD;
            end
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      if (r.status != ST_OK) begin
         r.index = '0;
      end
      r.version = changes;
      return r;
   endfunction

   always @(posedge clock) begin
      pool_result_t want;
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            live_map[k]  = 1'b0;
            next_free[k] = '0;
         end
         free_top = END_MARK;
         mark     = '0;
         changes  = '0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_pool_op(req_func, req_slot_index));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               failures++;
               if (reports < 10) begin
                  reports++;
                  $display("%0t: result with no item outstanding: status %0d index %0d version %0d",
                           $realtime, rsp_status, rsp_result_index, rsp_version);
               end
            end else begin
               want = awaited_results.pop_front();
               if (want.status != rsp_status || want.index != rsp_result_index ||
                   want.version != rsp_version) begin
                  failures++;
                  if (reports < 10) begin
                     reports++;
                     $display("%0t: result mismatch (expected/actual): status %0d/%0d index %0d/%0d version %0d/%0d",
                              $realtime, want.status, rsp_status, want.index, rsp_result_index,
                              want.version, rsp_version);
                  end
               end
            end
         end
      end
      fail_count    <= failures;
      pending_count <= awaited_results.size();
   end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the slot pool allocator. A short directed run
// covers every operation and the corner cases, then random traffic churns a
// small pool, fills the pool to exhaustion and works on it while full. Both
// channels idle at random; the checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   // The two operation codes that the block must reject.
   localparam logic [2:0] FUNC_RSVD_A  = 3'd6;
   localparam logic [2:0] FUNC_RSVD_B  = 3'd7;

   // Cycle limit past which the run counts as hung.
   localparam int LIMIT_CYCLES = 1_000_000;
   // Cycles allowed after the last result for a stray result to show up.
   localparam int DRAIN_CYCLES = 40;
   // Length of the long receiver hold-off that backs the block up.
   localparam int HOLD_CYCLES  = 400;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [2:0]        req_func       = FUNC_ALLOC;
   logic [SLOT_W-1:0] req_slot_index = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_result_index;
   logic [VER_W-1:0]  rsp_version;

   int                fail_count;
   int                pending_count;
   int                cycle_count    = 0;
   int                items_sent     = 0;
   int                results_taken  = 0;
   // Rough idea of the high-water mark, used only to aim slot indexes at the
   // part of the pool that is in use. The checker keeps the exact state.
   int                mark_guess     = 0;
   logic              quiet_tx       = 1'b0;
   logic              quiet_rx       = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   slot_pool_allocator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_version      (rsp_version)
   );

   pool_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_version      (rsp_version),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Idle lengths for either side: mostly none or short, now and then long.
   // The long ones outlast a full search, so gaps land on every phase of the
   // block's sequencing.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A slot index mostly inside the used part of the pool, so that frees,
   // tests and searches mostly hit live slots; the rest covers the full range.
   function automatic logic [SLOT_W-1:0] aimed_slot();
      if (mark_guess > 0 && $urandom_range(0, 99) < 85) begin
         return SLOT_W'($urandom_range(0, mark_guess - 1));
      end
      return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
   endfunction

   // Offers one item and returns at the clock edge where it is accepted.
   // The valid is only lowered when a gap follows, so back-to-back items keep
   // it high without a second assignment in the same time step. The payload
   // stays put while the block stalls.
   task automatic send_item(input logic [2:0] op, input logic [SLOT_W-1:0] slot);
      int gap;
      // Every 64 items decide whether the next stretch runs without gaps.
      if (items_sent % 64 == 0) begin
         quiet_tx = ($urandom_range(0, 3) == 0);
      end
      gap = quiet_tx ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= op;
      req_slot_index <= slot;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == FUNC_ALLOC && mark_guess < NUM_SLOTS) begin
         mark_guess++;
      end
      if (op == FUNC_CLEAR) begin
         mark_guess = 0;
      end
   endtask

   // One item of general traffic on a pool that grows and shrinks; a clear
   // now and then keeps the pool small so searches stay short.
   task automatic send_mixed_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 34) begin
         send_item(FUNC_ALLOC, SLOT_W'($urandom));
      end else if (r < 57) begin
         send_item(FUNC_FREE, aimed_slot());
      end else if (r < 59) begin
         send_item(FUNC_CLEAR, SLOT_W'($urandom));
      end else if (r < 71) begin
         send_item(FUNC_FWD, aimed_slot());
      end else if (r < 83) begin
         send_item(FUNC_BWD, aimed_slot());
      end else if (r < 96) begin
         send_item(FUNC_TEST, aimed_slot());
      end else begin
         send_item(r[0] ? FUNC_RSVD_A : FUNC_RSVD_B, SLOT_W'($urandom));
      end
   endtask

   // A search or a test, for mixing into allocation runs.
   task automatic send_lookup();
      case ($urandom_range(0, 2))
         0:       send_item(FUNC_FWD, aimed_slot());
         1:       send_item(FUNC_BWD, aimed_slot());
         default: send_item(FUNC_TEST, aimed_slot());
      endcase
   endtask

   // Receiver. Before each result it may stall for a while, with stretches
   // of no stalling at all. Twice it holds off for a long time while the
   // sender keeps offering items, so the block backs up and stalls its input.
   initial begin
      int stall_len;
      while (reset) @(posedge clock);
      forever begin
         if (results_taken % 80 == 0) begin
            quiet_rx = ($urandom_range(0, 3) == 0);
         end
         if (results_taken == 150 || results_taken == 1300) begin
            stall_len = HOLD_CYCLES;
         end else begin
            stall_len = quiet_rx ? 0 : pick_gap();
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
      end
   end

   // A run that hangs, or that leaves an expected result unanswered, ends
   // here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Main sequence: reset, directed items, random phases, then the verdict.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On an empty pool every lookup and free must fail.
      send_item(FUNC_TEST,  10'd0);
      send_item(FUNC_FWD,   10'd0);
      send_item(FUNC_BWD,   10'd1023);
      send_item(FUNC_FREE,  10'd0);
      // Four fresh slots come from the high-water mark: 0, 1, 2, 3.
      send_item(FUNC_ALLOC, 10'd1023);
      send_item(FUNC_ALLOC, 10'd0);
      send_item(FUNC_ALLOC, 10'd512);
      send_item(FUNC_ALLOC, 10'd341);
      // A good free, then a double free and a test of the dead slot.
      send_item(FUNC_FREE,  10'd1);
      send_item(FUNC_FREE,  10'd1);
      send_item(FUNC_TEST,  10'd1);
      send_item(FUNC_TEST,  10'd2);
      // Searches that step over the dead slot in both directions.
      send_item(FUNC_FWD,   10'd1);
      send_item(FUNC_BWD,   10'd1);
      send_item(FUNC_FREE,  10'd0);
      // Backward search finding nothing, forward search starting at the mark.
      send_item(FUNC_BWD,   10'd1);
      send_item(FUNC_FWD,   10'd4);
      // Test above the mark and both undefined operation codes.
      send_item(FUNC_TEST,  10'd1023);
      send_item(FUNC_RSVD_A, 10'd1023);
      send_item(FUNC_RSVD_B, 10'd0);
      // The free list hands back 0, then 1, in last-in-first-out order, and
      // only then does the mark move again.
      send_item(FUNC_ALLOC, 10'd0);
      send_item(FUNC_ALLOC, 10'd0);
      send_item(FUNC_ALLOC, 10'd0);
      // Clear, then a search on the emptied pool.
      send_item(FUNC_CLEAR, 10'd682);
      send_item(FUNC_FWD,   10'd0);

      // General traffic on a small pool.
      repeat (420) send_mixed_item();

      // Fill the whole pool from empty, with lookups mixed in. No frees are
      // sent here, so every allocation raises the mark and the guess is exact.
      send_item(FUNC_CLEAR, SLOT_W'($urandom));
      while (mark_guess < NUM_SLOTS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_lookup();
         end else begin
            send_item(FUNC_ALLOC, SLOT_W'($urandom));
         end
      end
      // The pool is exhausted: these must all report pool full.
      repeat (6) send_item(FUNC_ALLOC, SLOT_W'($urandom));

      // Work on the full pool: frees anywhere, allocations that drain the
      // free list and run into the full pool again, and lookups.
      repeat (160) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
               send_item(FUNC_FREE, SLOT_W'($urandom));
            10, 11, 12, 13, 14, 15, 16:
               send_item(FUNC_ALLOC, SLOT_W'($urandom));
            default:
               send_lookup();
         endcase
      end

      // More general traffic, starting from a cleared pool.
      send_item(FUNC_CLEAR, SLOT_W'($urandom));
      repeat (320) send_mixed_item();

      // Let the checker see the last accepted item, wait for every expected
      // result, then give a stray result time to appear.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
